/* hdl/pldm_pkg.sv */
// Shared types, field widths and stream packing offsets for the positional list unit.
package pldm_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int MINPOS_W = 4;
   localparam int COUNT_W  = 5;

   // Request stream: tdata = value, position; tuser = operation.
   localparam int REQ_TDATA_W   = 40;
   localparam int REQ_TUSER_W   = 1;
   localparam int REQ_VALUE_LSB = 0;
   localparam int REQ_POS_LSB   = 32;

   // Response stream: tdata = removed_value, min_position, min_value, item_count;
   // tuser = status, min_valid.
   localparam int RSP_TDATA_W     = 80;
   localparam int RSP_TUSER_W     = 3;
   localparam int RSP_REMOVED_LSB = 0;
   localparam int RSP_MINPOS_LSB  = 32;
   localparam int RSP_MINVAL_LSB  = 36;
   localparam int RSP_COUNT_LSB   = 68;
   localparam int RSP_STATUS_LSB  = 0;
   localparam int RSP_MINVLD_BIT  = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   // Control part of the token that walks the row of cells.
   typedef struct packed {
      logic               valid;
      logic               ins;
      logic               del;
      logic [POS_W-1:0]   position;
      status_type         status;
   } tok_ctl_type;

endpackage

/* hdl/pldm_cell.sv */
// One list cell: holds an entry, applies the shift as the token passes, folds in the minimum.
module pldm_cell #(
   parameter int DEPTH = pldm_pkg::DEPTH_DEFAULT,
   parameter int K     = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          hold,
   input  pldm_pkg::tok_ctl_type         ctl_i,
   input  logic [pldm_pkg::VALUE_W-1:0]  carry_i,
   input  logic [pldm_pkg::VALUE_W-1:0]  min_val_i,
   input  logic [$clog2(DEPTH)-1:0]      min_pos_i,
   input  logic [$clog2(DEPTH+1)-1:0]    cnt_i,
   input  logic [pldm_pkg::VALUE_W-1:0]  right_i,
   output logic [pldm_pkg::VALUE_W-1:0]  entry_o,
   output pldm_pkg::tok_ctl_type         ctl_o,
   output logic [pldm_pkg::VALUE_W-1:0]  carry_o,
   output logic [pldm_pkg::VALUE_W-1:0]  min_val_o,
   output logic [$clog2(DEPTH)-1:0]      min_pos_o,
   output logic [$clog2(DEPTH+1)-1:0]    cnt_o
);
   import pldm_pkg::*;

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH+1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CMPW-1:0] IDX = CMPW'(K);

   logic [VALUE_W-1:0] entry_ff, entry_in;
   tok_ctl_type        ctl_ff, ctl_in;
   logic [VALUE_W-1:0] carry_ff, carry_in;
   logic [VALUE_W-1:0] min_val_ff, min_val_in;
   logic [IW-1:0]      min_pos_ff, min_pos_in;
   logic [CW-1:0]      cnt_ff;
   logic [CMPW-1:0]    pos_x;
   logic               at_pos, from_pos, live, take;

   always_comb begin
      pos_x    = CMPW'(ctl_i.position);
      at_pos   = (IDX == pos_x);
      from_pos = (IDX >= pos_x);
      entry_in = entry_ff;
      carry_in = carry_i;
      // Insert ripples the displaced entry upwards through the carry.
      if (ctl_i.valid && ctl_i.ins && from_pos) begin
         entry_in = carry_i;
         carry_in = entry_ff;
      end
      // Delete pulls the right neighbour down; the cell at the position hands its entry out.
      if (ctl_i.valid && ctl_i.del && from_pos) begin
         entry_in = right_i;
      end
      if (ctl_i.valid && ctl_i.del && at_pos) begin
         carry_in = entry_ff;
      end
      live       = (IDX < CMPW'(cnt_i));
      take       = live && ((K == 0) || ($signed(entry_in) < $signed(min_val_i)));
      min_val_in = take ? entry_in : min_val_i;
      min_pos_in = take ? IW'(K) : min_pos_i;
      ctl_in     = ctl_i;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (!hold) begin
         ctl_ff <= ctl_in;
      end
      if (!hold) begin
         carry_ff   <= carry_in;
         min_val_ff <= min_val_in;
         min_pos_ff <= min_pos_in;
         cnt_ff     <= cnt_i;
      end
   end

   assign entry_o   = entry_ff;
   assign ctl_o     = ctl_ff;
   assign carry_o   = carry_ff;
   assign min_val_o = min_val_ff;
   assign min_pos_o = min_pos_ff;
   assign cnt_o     = cnt_ff;

endmodule

/* hdl/positional_list_insert_delete_min_unit.sv */
// Top level of the positional list unit: insert, delete and minimum report over a row of cells.
//
//   Channel    Direction  Handshake          tdata (lowest bit first)             tuser
//   req_       in         tvalid / tready    value[31:0], position[36:32], pad    operation
//   rsp_       out        tvalid / tready    removed_value, min_position,         status,
//                                            min_value, item_count, pad           min_valid
//
// A transaction on req_ launches a token into the row of DEPTH cells. The token visits one
// cell per cycle, carrying out the shift of the insert or delete at that cell and folding the
// cell's new entry into the running minimum; only the last cell can hold it, behind a stalled
// response. From the last cell the response is registered, and a new request is taken only
// once the token has left the row.
// Reset is synchronous and active high; it empties the list and drops any token in flight.
// The list entries themselves are not cleared. A stalled response holds the token in the last
// cell; a new request may be taken while a finished response waits to be collected.
module positional_list_insert_delete_min_unit #(
   parameter int DEPTH = pldm_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // value[31:0], position[36:32], zeros above
   input  logic [pldm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // operation[0]
   input  logic [pldm_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // removed_value[31:0], min_position[35:32], min_value[67:36], item_count[72:68], zeros above
   output logic [pldm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // status[1:0], min_valid[2]
   output logic [pldm_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import pldm_pkg::*;

   localparam int IW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH+1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   // Token wires: index 0 is the launch register, index k+1 the output of cell k.
   tok_ctl_type        ctl_w     [DEPTH+1];
   logic [VALUE_W-1:0] carry_w   [DEPTH+1];
   logic [VALUE_W-1:0] min_val_w [DEPTH+1];
   logic [IW-1:0]      min_pos_w [DEPTH+1];
   logic [CW-1:0]      cnt_w     [DEPTH+1];
   logic [VALUE_W-1:0] entry_w   [DEPTH];

   tok_ctl_type        launch_ctl_ff, launch_ctl_in;
   logic [VALUE_W-1:0] launch_carry_ff, launch_carry_in;
   logic [CW-1:0]      launch_cnt_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic               accept, rsp_load, last_hold;
   op_type             req_op;
   logic [VALUE_W-1:0] req_value;
   logic [POS_W-1:0]   req_pos;
   logic [CMPW-1:0]    pos_x, cnt_x;
   tok_ctl_type        last_ctl;
   logic [VALUE_W-1:0] removed;

   assign req_op    = op_type'(req_tuser[0]);
   assign req_value = req_tdata[REQ_VALUE_LSB +: VALUE_W];
   assign req_pos   = req_tdata[REQ_POS_LSB +: POS_W];
   assign pos_x     = CMPW'(req_pos);
   assign cnt_x     = CMPW'(cnt_ff);

   // One item in the row at a time; the request side waits until its token has left the row.
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;

   // The last cell only freezes while it holds a finished token that cannot be handed over,
   // so a token arriving behind a waiting response is still captured.
   assign last_ctl  = ctl_w[DEPTH];
   assign last_hold = last_ctl.valid && rsp_valid_ff && !rsp_tready;
   assign rsp_load  = last_ctl.valid && !last_hold;

   // Decide the outcome up front from the count; the cells only carry it out.
   always_comb begin
      launch_ctl_in          = '0;
      launch_ctl_in.valid    = accept;
      launch_ctl_in.position = req_pos;
      launch_ctl_in.status   = ST_DONE;
      launch_carry_in        = '0;
      cnt_in                 = cnt_ff;
      if (req_op == OP_INSERT) begin
         if (pos_x > cnt_x) begin
            launch_ctl_in.status = ST_BAD_POS;
         end else if (cnt_ff == CW'(DEPTH)) begin
            launch_ctl_in.status = ST_FULL;
         end else begin
            launch_ctl_in.ins = 1'b1;
            launch_carry_in   = req_value;
            cnt_in            = cnt_ff + 1'b1;
         end
      end else begin
         if (pos_x >= cnt_x) begin
            launch_ctl_in.status = ST_BAD_POS;
         end else begin
            launch_ctl_in.del = 1'b1;
            cnt_in            = cnt_ff - 1'b1;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (rsp_load) begin
         busy_in = 1'b0;
      end
   end

   // The carry of a finished delete is the entry it took out.
   assign removed = last_ctl.del ? carry_w[DEPTH] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_tdata_in = '0;
         rsp_tdata_in[RSP_REMOVED_LSB +: VALUE_W]  = removed;
         rsp_tdata_in[RSP_MINPOS_LSB +: MINPOS_W]  = MINPOS_W'(min_pos_w[DEPTH]);
         rsp_tdata_in[RSP_MINVAL_LSB +: VALUE_W]   = min_val_w[DEPTH];
         rsp_tdata_in[RSP_COUNT_LSB +: COUNT_W]    = COUNT_W'(cnt_w[DEPTH]);
         rsp_tuser_in[RSP_STATUS_LSB +: STATUS_W]  = last_ctl.status;
         rsp_tuser_in[RSP_MINVLD_BIT]              = (cnt_w[DEPTH] != '0);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ctl_ff.valid <= 1'b0;
         cnt_ff              <= '0;
         busy_ff             <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         launch_ctl_ff <= launch_ctl_in;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      launch_carry_ff <= launch_carry_in;
      launch_cnt_ff   <= cnt_in;
      rsp_tdata_ff    <= rsp_tdata_in;
      rsp_tuser_ff    <= rsp_tuser_in;
   end

   assign ctl_w[0]     = launch_ctl_ff;
   assign carry_w[0]   = launch_carry_ff;
   assign min_val_w[0] = '0;
   assign min_pos_w[0] = '0;
   assign cnt_w[0]     = launch_cnt_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [VALUE_W-1:0] right;
      if (k == DEPTH-1) begin : g_end
         assign right = entry_w[k];
      end else begin : g_mid
         assign right = entry_w[k+1];
      end
      pldm_cell #(
         .DEPTH (DEPTH),
         .K     (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .hold      ((k == DEPTH-1) ? last_hold : 1'b0),
         .ctl_i     (ctl_w[k]),
         .carry_i   (carry_w[k]),
         .min_val_i (min_val_w[k]),
         .min_pos_i (min_pos_w[k]),
         .cnt_i     (cnt_w[k]),
         .right_i   (right),
         .entry_o   (entry_w[k]),
         .ctl_o     (ctl_w[k+1]),
         .carry_o   (carry_w[k+1]),
         .min_val_o (min_val_w[k+1]),
         .min_pos_o (min_pos_w[k+1]),
         .cnt_o     (cnt_w[k+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* hdl/pldm_checker.sv */
// Port-level checks for the positional list unit, bound to the top level.
module pldm_checker #(
   parameter int DEPTH = pldm_pkg::DEPTH_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [pldm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic [pldm_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pldm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [pldm_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import pldm_pkg::*;

   logic [COUNT_W-1:0]  count;
   logic [STATUS_W-1:0] status;

   assign count  = rsp_tdata[RSP_COUNT_LSB +: COUNT_W];
   assign status = rsp_tuser[RSP_STATUS_LSB +: STATUS_W];

   // Only one item is worked on at a time, so a request is never taken twice in a row.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on two consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (DEPTH < 32) |-> count <= COUNT_W'(DEPTH))
      else $error("item count exceeds the depth");

   a_min_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (DEPTH < 32) |-> rsp_tuser[RSP_MINVLD_BIT] == (count != '0))
      else $error("min_valid disagrees with item count");

   a_refused_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status != ST_DONE) |-> rsp_tdata[RSP_REMOVED_LSB +: VALUE_W] == '0)
      else $error("refused operation returned a removed value");

endmodule

bind positional_list_insert_delete_min_unit pldm_checker #(.DEPTH(DEPTH)) u_pldm_checker (.*);

/* tb/tb_positional_list_insert_delete_min_unit.sv */
// Self-checking testbench for the positional list unit: stream stimulus, list predictor and response checks.
module tb_positional_list_insert_delete_min_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pldm_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1650;
   // The slowest correct run is roughly 1700 items times (longest request gap + walk along
   // the row + longest response stall); the limit allows about five times that.
   localparam int CYCLE_LIMIT  = 1200000;
   // One token walk plus some margin, so that a stray late response would still be caught.
   localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
   localparam int REPORT_LIMIT = 10;

   // One request transaction as the stimulus sees it.
   typedef struct {
      op_type             op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
   } list_request_type;

   // One response transaction, unpacked into its fields.
   typedef struct packed {
      status_type          status;
      logic [VALUE_W-1:0]  removed;
      logic                min_valid;
      logic [MINPOS_W-1:0] min_position;
      logic [VALUE_W-1:0]  min_value;
      logic [COUNT_W-1:0]  count;
   } list_report_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   positional_list_insert_delete_min_unit #(
      .DEPTH (LIST_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Requests still to be offered, and reports still owed by the block, oldest first.
   list_request_type pending_requests[$];
   list_report_type  owed_reports[$];

   // The predictor's own copy of the list. Only entries below the count are ever read.
   logic signed [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
   int unsigned               shadow_count;

   // Count of entries as the stimulus planner expects it, used to aim positions at the
   // valid range. It follows the same rules as the predictor but runs ahead of the block.
   int unsigned plan_count;

   int  error_count;
   int  cycle_count;
   bit  req_taken;      // the request on offer was accepted at the last rising edge
   int  send_gap;
   int  send_calm;
   int  hold_left;
   int  hold_calm;

   // 4 ns clock period.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one operation to the shadow list and works out the report the block must give.
   function automatic list_report_type apply_list_op(op_type op, logic [VALUE_W-1:0] value,
                                                     int unsigned position);
      list_report_type           rep;
      logic signed [VALUE_W-1:0] smallest;
      rep        = '0;
      rep.status = ST_DONE;
      if (op == OP_INSERT) begin
         // A position beyond the end is checked before fullness.
         if (position > shadow_count) begin
            rep.status = ST_BAD_POS;
         end else if (shadow_count >= LIST_DEPTH) begin
            rep.status = ST_FULL;
         end else begin
            for (int i = shadow_count; i > position; i--) begin
               shadow_entries[i] = shadow_entries[i-1];
            end
            shadow_entries[position] = value;
            shadow_count++;
         end
      end else begin
         if (position >= shadow_count) begin
            rep.status = ST_BAD_POS;
         end else begin
            rep.removed = shadow_entries[position];
            for (int i = position; i + 1 < shadow_count; i++) begin
               shadow_entries[i] = shadow_entries[i+1];
            end
            shadow_count--;
         end
      end
      // The first smallest entry wins, so only a strictly smaller one moves the position.
      if (shadow_count > 0) begin
         rep.min_valid = 1'b1;
         smallest      = shadow_entries[0];
         for (int i = 1; i < shadow_count; i++) begin
            if (shadow_entries[i] < smallest) begin
               smallest         = shadow_entries[i];
               rep.min_position = MINPOS_W'(i);
            end
         end
         rep.min_value = smallest;
      end
      rep.count = shadow_count[COUNT_W-1:0];
      return rep;
   endfunction

   // Gap lengths for either side: mostly none or short, now and then long, and from time to
   // time a stretch of several dozen transactions with no gap at all.
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 199);
      if (roll < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 110) return 0;
      if (roll < 170) return $urandom_range(1, 3);
      if (roll < 194) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Queues a request and keeps the planner's count in step with it.
   task automatic plan_request(op_type op, logic [VALUE_W-1:0] value, int unsigned position);
      list_request_type item;
      item.op       = op;
      item.value    = value;
      item.position = position[POS_W-1:0];
      pending_requests.push_back(item);
      if (op == OP_INSERT) begin
         if (position <= plan_count && plan_count < LIST_DEPTH) plan_count++;
      end else if (position < plan_count) begin
         plan_count--;
      end
   endtask

   // Directed opening: empty list refusals, extreme values, equal minima, filling the list,
   // refusals on a full list, and deletes at both ends.
   task automatic plan_directed();
      plan_request(OP_DELETE, 32'h0000_0000, 0);           // delete from an empty list
      plan_request(OP_DELETE, 32'hFFFF_FFFF, 31);          // delete far out of range
      plan_request(OP_INSERT, 32'h1234_5678, 1);           // insert past the end of an empty list
      plan_request(OP_INSERT, 32'h7FFF_FFFF, 0);           // largest value
      plan_request(OP_INSERT, 32'h8000_0000, 1);           // smallest value, appended
      plan_request(OP_INSERT, 32'hFFFF_FFFB, 0);           // insert at the front
      plan_request(OP_INSERT, 32'h8000_0000, 1);           // second copy of the minimum, earlier
      // Fill the list: alternate appends with inserts at random places.
      for (int i = 0; i < 12; i++) begin
         if (i % 2 == 0) plan_request(OP_INSERT, $urandom(), plan_count);
         else            plan_request(OP_INSERT, $urandom(), $urandom_range(0, plan_count));
      end
      plan_request(OP_INSERT, 32'h0000_0001, LIST_DEPTH);      // list full, position in range
      plan_request(OP_INSERT, 32'h0000_0002, LIST_DEPTH + 1);  // list full and past the end
      plan_request(OP_INSERT, 32'h0000_0003, 31);              // largest position
      plan_request(OP_DELETE, 32'h0000_0000, LIST_DEPTH - 1);  // delete the last entry
      plan_request(OP_DELETE, 32'h0000_0000, 0);               // delete the first entry
      plan_request(OP_DELETE, 32'h0000_0000, LIST_DEPTH);      // delete beyond the count
   endtask

   // Random part. The trend switches between growing, shrinking and balanced, so that the
   // list swings between empty and full many times; most positions aim inside the valid
   // range and the rest cover the whole field.
   task automatic plan_random();
      int            trend;
      int            trend_left;
      int            insert_share;
      int            roll;
      op_type        op;
      logic [31:0]   value;
      int unsigned   position;
      trend      = 0;
      trend_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (trend_left == 0) begin
            trend      = $urandom_range(0, 2);
            trend_left = $urandom_range(30, 80);
         end
         trend_left--;
         insert_share = (trend == 0) ? 80 : (trend == 1) ? 20 : 50;
         op = ($urandom_range(0, 99) < insert_share) ? OP_INSERT : OP_DELETE;

         roll = $urandom_range(0, 99);
         if (roll < 40)      value = $urandom();
         else if (roll < 70) value = int'($urandom_range(0, 15)) - 8;   // many ties
         else if (roll < 82) begin
            case ($urandom_range(0, 3))
               0:       value = 32'h8000_0000;
               1:       value = 32'h7FFF_FFFF;
               2:       value = 32'hFFFF_FFFF;
               default: value = 32'h0000_0000;
            endcase
         end else begin
            value = 32'h8000_0000 + $urandom_range(0, 3);
         end

         if ($urandom_range(0, 99) < 85) begin
            if (op == OP_INSERT)     position = $urandom_range(0, plan_count);
            else if (plan_count > 0) position = $urandom_range(0, plan_count - 1);
            else                     position = $urandom_range(0, 31);
         end else begin
            position = $urandom_range(0, 31);
         end
         plan_request(op, value, position);
      end
   endtask

   // Request driver: changes its outputs at the falling edge. A request stays on offer until
   // the transaction completes, then the next one follows after its own random gap.
   always @(negedge clock) begin
      list_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            item = pending_requests.pop_front();
            req_tdata  <= {{(REQ_TDATA_W - POS_W - VALUE_W){1'b0}}, item.position, item.value};
            req_tuser  <= item.op;
            req_tvalid <= 1'b1;
            send_gap   = pick_gap(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response back-pressure: stalls of random length, also driven at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         hold_left = pick_gap(hold_calm);
      end
   end

   // Monitor: samples both channels at the rising edge. A completed response transaction is
   // checked against the oldest owed report before any request of the same edge is predicted;
   // a request's own response can never come back in the cycle it is taken.
   always @(posedge clock) begin
      list_report_type got;
      list_report_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status       = status_type'(rsp_tuser[RSP_STATUS_LSB +: STATUS_W]);
            got.min_valid    = rsp_tuser[RSP_MINVLD_BIT];
            got.removed      = rsp_tdata[RSP_REMOVED_LSB +: VALUE_W];
            got.min_position = rsp_tdata[RSP_MINPOS_LSB +: MINPOS_W];
            got.min_value    = rsp_tdata[RSP_MINVAL_LSB +: VALUE_W];
            got.count        = rsp_tdata[RSP_COUNT_LSB +: COUNT_W];
            if (owed_reports.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: response with nothing owed: status %0d count %0d",
                           $realtime, got.status, got.count);
            end else begin
               want = owed_reports.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display({"%0t: mismatch exp status %0d removed %h valid %b minpos %0d ",
                               "minval %h count %0d / got %0d %h %b %0d %h %0d"},
                              $realtime, want.status, want.removed, want.min_valid,
                              want.min_position, want.min_value, want.count, got.status,
                              got.removed, got.min_valid, got.min_position, got.min_value,
                              got.count);
               end
            end
         end
         req_taken = req_tvalid && req_tready;
         if (req_taken)
            owed_reports.push_back(apply_list_op(op_type'(req_tuser[0]),
                                                 req_tdata[REQ_VALUE_LSB +: VALUE_W],
                                                 req_tdata[REQ_POS_LSB +: POS_W]));
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[positional_list_insert_delete_min_unit] ERROR");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      rsp_tready   = 1'b0;
      shadow_count = 0;
      plan_count   = 0;
      error_count  = 0;
      cycle_count  = 0;
      req_taken    = 1'b0;
      send_gap     = 0;
      send_calm    = 0;
      hold_left    = 0;
      hold_calm    = 0;

      plan_directed();
      plan_random();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every request has gone in and every owed report has come back.
      while (pending_requests.size() != 0 || req_tvalid || owed_reports.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && owed_reports.size() == 0) begin
         $display("[positional_list_insert_delete_min_unit] OK");
      end else begin
         $display("[positional_list_insert_delete_min_unit] ERROR");
      end
      $finish;
   end

endmodule
